>>> rtl/tcsum_pkg.sv
package tcsum_pkg;

  localparam int unsigned WORD_W     = 16;
  localparam int unsigned IP_ADDR_W  = 32;
  localparam int unsigned PROTO_W    = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [PROTO_W-1:0] PROTO_RESET = 8'd6;

  // register index, taken from paddr above the byte offset
  localparam logic REG_PROTOCOL_NUMBER = 1'b0;

  // one finished segment handed from the front to the back
  typedef struct packed {
    logic [WORD_W-1:0]    sum;
    logic [WORD_W-1:0]    len;
    logic [IP_ADDR_W-1:0] src;
    logic [IP_ADDR_W-1:0] dst;
  } tcsum_entry_t;

endpackage

>>> rtl/tcsum_if.sv
interface tcsum_in_if;
  import tcsum_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [WORD_W-1:0]    data_word;
  logic                 single_byte;
  logic                 last_word;
  logic [IP_ADDR_W-1:0] src_addr;
  logic [IP_ADDR_W-1:0] dst_addr;

  modport source (
    output valid, data_word, single_byte, last_word, src_addr, dst_addr,
    input  ready
  );
  modport sink (
    input  valid, data_word, single_byte, last_word, src_addr, dst_addr,
    output ready
  );
endinterface

interface tcsum_out_if;
  import tcsum_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] checksum;

  modport source (output valid, checksum, input ready);
  modport sink (input valid, checksum, output ready);
endinterface

>>> rtl/tcsum_front.sv
module tcsum_front #(
  parameter int unsigned CHECKSUM_WORD_POS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  tcsum_in_if.sink               in_ch,
  output logic                   push_valid,
  input  logic                   push_ready,
  output tcsum_pkg::tcsum_entry_t push_data
);
  import tcsum_pkg::*;

  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [WORD_W-1:0] cnt_r, cnt_nxt;
  logic              single;
  logic              accept;
  logic [WORD_W-1:0] word;
  logic [WORD_W:0]   raw_sum;
  logic [WORD_W-1:0] sum_add;
  logic [WORD_W-1:0] sum_upd;
  logic [WORD_W-1:0] len_upd;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid & push_ready;
  assign push_valid  = in_ch.valid & in_ch.last_word;

  always_comb begin
    single  = in_ch.last_word & in_ch.single_byte;
    word    = single ? {in_ch.data_word[WORD_W-1:8], 8'h00} : in_ch.data_word;
    raw_sum = {1'b0, acc_r} + {1'b0, word};
    // end-around carry
    sum_add = raw_sum[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, raw_sum[WORD_W]};
    // checksum field is counted in the length but not summed
    sum_upd = (cnt_r[WORD_W-1:1] == (WORD_W-1)'(CHECKSUM_WORD_POS)) ? acc_r : sum_add;
    len_upd = cnt_r + (single ? 16'd1 : 16'd2);

    push_data.sum = sum_upd;
    push_data.len = len_upd;
    push_data.src = in_ch.src_addr;
    push_data.dst = in_ch.dst_addr;

    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      if (in_ch.last_word) begin
        acc_nxt = '0;
        cnt_nxt = '0;
      end else begin
        acc_nxt = sum_upd;
        cnt_nxt = len_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // segment state is cleared once the final transfer is taken
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.last_word) |=> (acc_r == '0 && cnt_r == '0))
    else $error("segment state not cleared after last word");

endmodule

>>> rtl/tcsum_fifo.sv
module tcsum_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push_valid,
  output logic                    push_ready,
  input  tcsum_pkg::tcsum_entry_t push_data,
  output logic                    pop_valid,
  input  logic                    pop_ready,
  output tcsum_pkg::tcsum_entry_t pop_data
);
  import tcsum_pkg::*;

  localparam int unsigned DEPTH = 2;

  tcsum_entry_t mem_r [DEPTH];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         push;
  logic         pop;

  assign push_ready = (cnt_r != 2'(DEPTH));
  assign pop_valid  = (cnt_r != 2'd0);
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(DEPTH))
    else $error("queue occupancy above depth");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'(DEPTH)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with occupancy");

endmodule

>>> rtl/tcsum_back.sv
module tcsum_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [7:0]              protocol_number,
  input  logic                    pop_valid,
  output logic                    pop_ready,
  input  tcsum_pkg::tcsum_entry_t pop_data,
  tcsum_out_if.source             out_ch
);
  import tcsum_pkg::*;

  logic                v1_r, v1_nxt;
  logic [WORD_W+1:0]   p1_r, p1_nxt;
  logic [WORD_W+1:0]   p2_r, p2_nxt;
  logic [PROTO_W-1:0]  proto_r;
  logic                v2_r, v2_nxt;
  logic [WORD_W+2:0]   tot_r, tot_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]   chk_r, chk_nxt;
  logic                adv;
  logic [WORD_W:0]     fold1;
  logic [WORD_W-1:0]   fold2;

  // whole pipeline holds while a finished result waits
  assign adv       = ~(out_valid_r & ~out_ch.ready);
  assign pop_ready = adv;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.checksum = chk_r;

  always_comb begin
    p1_nxt = {2'b00, pop_data.sum}
           + {2'b00, pop_data.src[IP_ADDR_W-1:WORD_W]}
           + {2'b00, pop_data.src[WORD_W-1:0]};
    p2_nxt = {2'b00, pop_data.dst[IP_ADDR_W-1:WORD_W]}
           + {2'b00, pop_data.dst[WORD_W-1:0]}
           + {2'b00, pop_data.len};
    tot_nxt = {1'b0, p1_r} + {1'b0, p2_r} + {{(WORD_W+3-PROTO_W){1'b0}}, proto_r};
    // two folds bring the sum back to 16 bits
    fold1   = {1'b0, tot_r[WORD_W-1:0]} + {{(WORD_W-2){1'b0}}, tot_r[WORD_W+2:WORD_W]};
    fold2   = fold1[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, fold1[WORD_W]};
    chk_nxt = ~fold2;

    v1_nxt        = adv ? pop_valid : v1_r;
    v2_nxt        = adv ? v1_r : v2_r;
    out_valid_nxt = adv ? v2_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r    <= p1_nxt;
      p2_r    <= p2_nxt;
      proto_r <= protocol_number;
      tot_r   <= tot_nxt;
      chk_r   <= chk_nxt;
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(v1_r) && $stable(v2_r) && $stable(out_valid_r) && $stable(chk_r)))
    else $error("pipeline moved during stall");

endmodule

>>> rtl/tcp_checksum_engine.sv
// TCP checksum engine over an IPv4 pseudo header. Segment words (first byte in bits 15..8)
// enter on in_ch at up to one transfer per cycle; the word at CHECKSUM_WORD_POS is counted
// but not summed, and a final single-byte transfer is zero padded. The transfer marked
// last also carries the source and destination addresses; its checksum passes the queue,
// the registered partial sums, total and fold, and is held on out_ch until out_ch is ready.
// The front takes one word per cycle while in_ch.ready is high, with an end-around-carry
// add; a two-entry queue before the pseudo-header pipeline lets input flow while a result
// waits, until the queue fills. protocol_number sits at byte address 0 of the APB port
// (reset 6); the user must write it only while the engine is idle; the engine does not enforce it.
module tcp_checksum_engine #(
  parameter int unsigned CHECKSUM_WORD_POS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  tcsum_in_if.sink                           in_ch,
  tcsum_out_if.source                        out_ch,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [tcsum_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [tcsum_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [tcsum_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                               cfg_pready
);
  import tcsum_pkg::*;

  logic [PROTO_W-1:0] proto_r, proto_nxt;
  logic               cfg_wr;
  logic               sel_proto;
  logic               push_valid;
  logic               push_ready;
  tcsum_entry_t       push_data;
  logic               pop_valid;
  logic               pop_ready;
  tcsum_entry_t       pop_data;

  assign cfg_pready = 1'b1;
  assign sel_proto  = (cfg_paddr[CFG_ADDR_W-1:2] == REG_PROTOCOL_NUMBER);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    proto_nxt  = (cfg_wr && sel_proto) ? cfg_pwdata[PROTO_W-1:0] : proto_r;
    cfg_prdata = sel_proto ? {{(CFG_DATA_W-PROTO_W){1'b0}}, proto_r} : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proto_r <= PROTO_RESET;
    end else begin
      proto_r <= proto_nxt;
    end
  end

  tcsum_front #(
    .CHECKSUM_WORD_POS (CHECKSUM_WORD_POS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  tcsum_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  tcsum_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .protocol_number (proto_r),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_data        (pop_data),
    .out_ch          (out_ch)
  );

endmodule
